FILE: design/triad_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triad_pkg
// Shared widths, types, command and status structures and small helpers
// for the TRIAD attitude block.
// ----------------------------------------------------------------------------
package triad_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int FRAC_BITS = 14;
	localparam int COEF_W    = 16;
	localparam int NORM_BITS = 30;
	localparam int MAG_W     = 32;
	localparam int XPROD_W   = 33;
	localparam int ACC_W     = 64;
	localparam int OPND_W    = 32;
	localparam int RAD_W     = 62;
	localparam int ROOT_W    = 31;
	localparam int QUO_W     = 15;
	localparam int DIVD_W    = 45;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;

	localparam coef_t ONE_Q = coef_t'(1 << FRAC_BITS);

	typedef enum logic [1:0] {
		MAC_CROSS,
		MAC_SQ,
		MAC_C0,
		MAC_MAT
	} mac_sel_t;

	typedef struct packed {
		logic     valid;
		mac_sel_t sel;
		logic [1:0] i;
		logic [1:0] j;
		logic [1:0] k;
		logic     last;
	} mac_cmd_t;

	typedef struct packed {
		logic       capture;
		logic       load_vec;
		logic       vsel;
		logic       shift;
		mac_cmd_t   mac;
		logic       sqrt_start;
		logic       div_start;
		logic [1:0] div_idx;
		logic       out_load;
		logic       degen;
	} dp_cmd_t;

	typedef struct packed {
		logic req_type;
		logic vec_zero;
		logic vec_norm;
		logic sqrt_done;
		logic div_done;
	} dp_stat_t;

	function automatic logic [1:0] inc3(input logic [1:0] x);
		return (x == 2'd2) ? 2'd0 : x + 2'd1;
	endfunction

	// Shift right by the fraction width, rounding half away from zero, and
	// clamp the magnitude to one.
	function automatic coef_t round_sat(input logic signed [31:0] x);
		logic [31:0] m;
		logic [31:0] r;
		m = x[31] ? 32'(-x) : 32'(x);
		r = (m + 32'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		if (r > 32'(1 << FRAC_BITS))
			r = 32'(1 << FRAC_BITS);
		return x[31] ? coef_t'(-r[COEF_W-1:0]) : coef_t'(r[COEF_W-1:0]);
	endfunction

endpackage
`default_nettype wire

FILE: design/triad_attitude.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triad_attitude
// TRIAD attitude frame from one accelerometer and one magnetometer vector.
// ----------------------------------------------------------------------------
// The input channel carries a request type and two raw signed 3-axis
// vectors. A store request builds the frame and keeps it as the reference;
// a compute request returns the frame times the transposed reference.
// Each accepted item gives exactly one result item on the output channel:
// nine Q1.14 matrix elements plus the ref_ready and degenerate flags.
// One item is processed at a time. Each of the two normalized vectors
// takes magnitude shifting, a sum of squares, the bit-serial square root
// with its start and done handshake and the divider for each component.
// The cross products, the first frame column and the 27-term matrix
// product run on the shared multiply-accumulate.
// A zero or parallel pair finishes early with a zero matrix.
// The result sits in an output register, so a new item is accepted while
// it waits; if the receiver stalls, the next result waits for the slot.
// Reset sets the reference to identity and clears ref_ready.
// ----------------------------------------------------------------------------
module triad_attitude
	import triad_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    req_type,
	input  sample_t accel_x,
	input  sample_t accel_y,
	input  sample_t accel_z,
	input  sample_t mag_x,
	input  sample_t mag_y,
	input  sample_t mag_z,
	output logic    out_valid,
	input  logic    out_ready,
	output coef_t   m00,
	output coef_t   m01,
	output coef_t   m02,
	output coef_t   m10,
	output coef_t   m11,
	output coef_t   m12,
	output coef_t   m20,
	output coef_t   m21,
	output coef_t   m22,
	output logic    ref_ready,
	output logic    degenerate
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	coef_t    om [3][3];

	triad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	triad_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_type    (req_type),
		.accel_x     (accel_x),
		.accel_y     (accel_y),
		.accel_z     (accel_z),
		.mag_x       (mag_x),
		.mag_y       (mag_y),
		.mag_z       (mag_z),
		.cmd         (cmd),
		.stat        (stat),
		.o_m         (om),
		.o_ref_ready (ref_ready),
		.o_degen     (degenerate)
	);

	assign m00 = om[0][0];
	assign m01 = om[0][1];
	assign m02 = om[0][2];
	assign m10 = om[1][0];
	assign m11 = om[1][1];
	assign m12 = om[1][2];
	assign m20 = om[2][0];
	assign m21 = om[2][1];
	assign m22 = om[2][2];

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again while an item is in work");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> (m00 == 0) && (m11 == 0) && (m22 == 0) && (m01 == 0))
		else $error("degenerate result carries a nonzero matrix");

	a_ref_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(ref_ready) |-> ref_ready)
		else $error("reference flag dropped after being set");

	a_elem_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (m22 <= 16'sd16384) && (m22 >= -16'sd16384))
		else $error("matrix element outside unit range");

endmodule
`default_nettype wire

FILE: design/triad_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triad_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module triad_sqrt
	import triad_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  rad,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int REM_W = ROOT_W + 4;

	logic              busy_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-1:0]  rem_n;
	logic [REM_W-1:0]  trial;

	always_comb begin
		rem_n = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
		trial = REM_W'({root_q, 2'b01});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

FILE: design/triad_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triad_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
module triad_div
	import triad_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [ROOT_W-1:0] divisor,
	output logic              done,
	output logic [QUO_W-1:0]  quo
);

	logic              busy_q;
	logic              done_q;
	logic [3:0]        cnt_q;
	logic [ROOT_W-1:0] rem_q;
	logic [QUO_W-1:0]  low_q;
	logic [QUO_W-1:0]  quo_q;
	logic [ROOT_W:0]   rem_n;
	logic [ROOT_W:0]   diff;

	always_comb begin
		rem_n = {rem_q, low_q[QUO_W-1]};
		diff  = rem_n - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The upper part of the dividend is already below the divisor.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= ROOT_W'(dividend[DIVD_W-1:QUO_W]);
			low_q <= dividend[QUO_W-1:0];
			quo_q <= '0;
		end else if (busy_q) begin
			low_q <= low_q << 1;
			if (rem_n >= {1'b0, divisor}) begin
				rem_q <= diff[ROOT_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_n[ROOT_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

FILE: design/triad_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triad_dp
// Datapath: input capture, shared multiply-accumulate, vector
// normalization with root and divider units, reference and result storage.
// ----------------------------------------------------------------------------
module triad_dp
	import triad_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_type,
	input  sample_t  accel_x,
	input  sample_t  accel_y,
	input  sample_t  accel_z,
	input  sample_t  mag_x,
	input  sample_t  mag_y,
	input  sample_t  mag_z,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	output coef_t    o_m [3][3],
	output logic     o_ref_ready,
	output logic     o_degen
);

	logic                       req_q;
	sample_t                    a_q [3];
	sample_t                    m_q [3];
	logic signed [XPROD_W-1:0]  x_q [3];
	logic [MAG_W-1:0]           t_q [3];
	logic                       tneg_q [3];
	logic                       vsel_q;
	logic signed [ACC_W-1:0]    prod_s1;
	logic signed [ACC_W-1:0]    acc_q;
	mac_cmd_t                   mop_s1;
	mac_cmd_t                   mop_s2;
	coef_t                      c0_q [3];
	coef_t                      c1_q [3];
	coef_t                      c2_q [3];
	coef_t                      w_q [3][3];
	coef_t                      ref_q [3][3];
	coef_t                      o_q [3][3];
	logic                       refv_q;
	logic                       o_ready_q;
	logic                       o_degen_q;

	logic [MAG_W-1:0]           vmag [3];
	logic                       vneg [3];
	logic signed [SAMPLE_W:0]   a_ext;
	logic [MAG_W-1:0]           mx01;
	logic [MAG_W-1:0]           mx;
	logic [1:0]                 i1;
	logic [1:0]                 i2;
	logic signed [OPND_W-1:0]   opa;
	logic signed [OPND_W-1:0]   opb;
	logic                       sqrt_done;
	logic                       div_done;
	logic [ROOT_W-1:0]          root;
	logic [QUO_W-1:0]           quo;
	logic [DIVD_W-1:0]          divd;
	logic [MAG_W-1:0]           t_sel;
	coef_t                      q_coef;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req_type;
			a_q[0] <= accel_x;
			a_q[1] <= accel_y;
			a_q[2] <= accel_z;
			m_q[0] <= mag_x;
			m_q[1] <= mag_y;
			m_q[2] <= mag_z;
		end
	end

	// Sign and magnitude of the vector being normalized.
	always_comb begin
		a_ext = '0;
		for (int n = 0; n < 3; n++) begin
			if (cmd.vsel) begin
				vneg[n] = x_q[n][XPROD_W-1];
				vmag[n] = x_q[n][XPROD_W-1] ? MAG_W'(-x_q[n]) : MAG_W'(x_q[n]);
			end else begin
				a_ext   = a_q[n];
				vneg[n] = a_ext[SAMPLE_W];
				vmag[n] = a_ext[SAMPLE_W] ? MAG_W'(-a_ext) : MAG_W'(a_ext);
			end
		end
	end

	always_comb begin
		mx01 = (t_q[0] > t_q[1]) ? t_q[0] : t_q[1];
		mx   = (mx01 > t_q[2]) ? mx01 : t_q[2];
	end

	// The largest magnitude is steered into [2^29, 2^30) one step a cycle;
	// a right shift truncates, as in the spec.
	always_ff @(posedge clk) begin
		if (cmd.load_vec) begin
			vsel_q <= cmd.vsel;
			for (int n = 0; n < 3; n++) begin
				t_q[n]    <= vmag[n];
				tneg_q[n] <= vneg[n];
			end
		end else if (cmd.shift) begin
			for (int n = 0; n < 3; n++) begin
				if (mx[MAG_W-1:NORM_BITS] != '0)
					t_q[n] <= t_q[n] >> 1;
				else if (mx[MAG_W-1:NORM_BITS-4] == '0)
					t_q[n] <= t_q[n] << 4;
				else
					t_q[n] <= t_q[n] << 1;
			end
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		i1  = inc3(cmd.mac.i);
		i2  = inc3(i1);
		opa = '0;
		opb = '0;
		case (cmd.mac.sel)
			MAC_CROSS: begin
				opa = (cmd.mac.k == 2'd0) ? a_q[i1] : a_q[i2];
				opb = (cmd.mac.k == 2'd0) ? m_q[i2] : m_q[i1];
			end
			MAC_SQ: begin
				opa = signed'(t_q[cmd.mac.k]);
				opb = signed'(t_q[cmd.mac.k]);
			end
			MAC_C0: begin
				opa = (cmd.mac.k == 2'd0) ? c1_q[i1] : c1_q[i2];
				opb = (cmd.mac.k == 2'd0) ? c2_q[i2] : c2_q[i1];
			end
			MAC_MAT: begin
				case (cmd.mac.k)
					2'd0:    opa = c0_q[cmd.mac.i];
					2'd1:    opa = c1_q[cmd.mac.i];
					default: opa = c2_q[cmd.mac.i];
				endcase
				opb = ref_q[cmd.mac.j][cmd.mac.k];
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mop_s1 <= '0;
			mop_s2 <= '0;
		end else begin
			mop_s1 <= cmd.mac;
			mop_s2 <= mop_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= opa * opb;
		if (mop_s1.valid) begin
			if (mop_s1.k == 2'd0)
				acc_q <= prod_s1;
			else if ((mop_s1.sel == MAC_CROSS || mop_s1.sel == MAC_C0) && mop_s1.k == 2'd1)
				acc_q <= acc_q - prod_s1;
			else
				acc_q <= acc_q + prod_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mop_s2.valid && mop_s2.last) begin
			case (mop_s2.sel)
				MAC_CROSS: x_q[mop_s2.i] <= acc_q[XPROD_W-1:0];
				MAC_C0:    c0_q[mop_s2.i] <= round_sat(acc_q[31:0]);
				MAC_MAT:   w_q[mop_s2.i][mop_s2.j] <= round_sat(acc_q[31:0]);
				default: ;
			endcase
		end
	end

	triad_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_start),
		.rad    (acc_q[RAD_W-1:0]),
		.done   (sqrt_done),
		.root   (root)
	);

	always_comb begin
		t_sel  = t_q[cmd.div_idx];
		divd   = (DIVD_W'(t_sel[NORM_BITS-1:0]) << FRAC_BITS) + DIVD_W'(root >> 1);
		q_coef = tneg_q[cmd.div_idx] ? coef_t'(-COEF_W'(quo)) : coef_t'(COEF_W'(quo));
	end

	triad_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (divd),
		.divisor  (root),
		.done     (div_done),
		.quo      (quo)
	);

	always_ff @(posedge clk) begin
		if (div_done) begin
			if (vsel_q)
				c1_q[cmd.div_idx] <= q_coef;
			else
				c2_q[cmd.div_idx] <= q_coef;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					ref_q[r][c] <= (r == c) ? ONE_Q : '0;
			refv_q    <= 1'b0;
			o_ready_q <= 1'b0;
			o_degen_q <= 1'b0;
		end else if (cmd.out_load) begin
			o_degen_q <= cmd.degen;
			if (cmd.degen) begin
				o_ready_q <= refv_q;
			end else if (!req_q) begin
				for (int r = 0; r < 3; r++) begin
					ref_q[r][0] <= c0_q[r];
					ref_q[r][1] <= c1_q[r];
					ref_q[r][2] <= c2_q[r];
				end
				refv_q    <= 1'b1;
				o_ready_q <= 1'b1;
			end else begin
				o_ready_q <= refv_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			for (int r = 0; r < 3; r++) begin
				if (cmd.degen) begin
					o_q[r][0] <= '0;
					o_q[r][1] <= '0;
					o_q[r][2] <= '0;
				end else if (!req_q) begin
					o_q[r][0] <= c0_q[r];
					o_q[r][1] <= c1_q[r];
					o_q[r][2] <= c2_q[r];
				end else begin
					o_q[r][0] <= w_q[r][0];
					o_q[r][1] <= w_q[r][1];
					o_q[r][2] <= w_q[r][2];
				end
			end
		end
	end

	always_comb begin
		stat.req_type  = req_q;
		stat.vec_zero  = (mx == '0);
		stat.vec_norm  = (mx[MAG_W-1:NORM_BITS-1] == 3'b001);
		stat.sqrt_done = sqrt_done;
		stat.div_done  = div_done;
	end

	assign o_m         = o_q;
	assign o_ref_ready = o_ready_q;
	assign o_degen     = o_degen_q;

endmodule
`default_nettype wire

FILE: design/triad_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triad_ctrl
// Sequencer: walks the datapath through cross product, two normalizations,
// the first frame column, the optional relative product and the result load.
// ----------------------------------------------------------------------------
module triad_ctrl
	import triad_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_CROSS = 10'b0000000010,
		S_LOAD  = 10'b0000000100,
		S_SHIFT = 10'b0000001000,
		S_SQ    = 10'b0000010000,
		S_SQRT  = 10'b0000100000,
		S_DIV   = 10'b0001000000,
		S_C0    = 10'b0010000000,
		S_MAT   = 10'b0100000000,
		S_FIN   = 10'b1000000000
	} state_t;

	state_t     state_q;
	state_t     mac_next;
	logic [1:0] i_q;
	logic [1:0] j_q;
	logic [1:0] k_q;
	logic [1:0] dcnt_q;
	logic       vsel_q;
	logic       go_q;
	logic       degen_q;
	logic       out_valid_q;

	logic       mac_phase;
	mac_sel_t   sel;
	logic [1:0] kmax;
	logic [1:0] jmax;
	logic [1:0] imax;
	logic       last_k;
	logic       last_all;
	logic       out_free;

	always_comb begin
		mac_phase = 1'b1;
		sel       = MAC_CROSS;
		kmax      = 2'd1;
		jmax      = 2'd0;
		imax      = 2'd2;
		mac_next  = S_LOAD;
		case (state_q)
			S_CROSS: begin
				sel      = MAC_CROSS;
				mac_next = S_LOAD;
			end
			S_SQ: begin
				sel      = MAC_SQ;
				kmax     = 2'd2;
				imax     = 2'd0;
				mac_next = S_SQRT;
			end
			S_C0: begin
				sel      = MAC_C0;
				mac_next = stat.req_type ? S_MAT : S_FIN;
			end
			S_MAT: begin
				sel      = MAC_MAT;
				kmax     = 2'd2;
				jmax     = 2'd2;
				mac_next = S_FIN;
			end
			default: mac_phase = 1'b0;
		endcase
		last_k   = (k_q == kmax);
		last_all = last_k && (j_q == jmax) && (i_q == imax);
		out_free = !out_valid_q || out_ready;
	end

	always_comb begin
		cmd            = '0;
		cmd.capture    = (state_q == S_IDLE) && in_valid;
		cmd.load_vec   = (state_q == S_LOAD);
		cmd.vsel       = vsel_q;
		cmd.shift      = (state_q == S_SHIFT) && !stat.vec_zero && !stat.vec_norm;
		cmd.mac.valid  = mac_phase && (dcnt_q == 2'd0);
		cmd.mac.sel    = sel;
		cmd.mac.i      = i_q;
		cmd.mac.j      = j_q;
		cmd.mac.k      = k_q;
		cmd.mac.last   = last_k;
		cmd.sqrt_start = (state_q == S_SQRT) && !go_q;
		cmd.div_start  = (state_q == S_DIV) && !go_q;
		cmd.div_idx    = i_q;
		cmd.out_load   = (state_q == S_FIN) && out_free;
		cmd.degen      = degen_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			dcnt_q  <= '0;
			vsel_q  <= 1'b0;
			go_q    <= 1'b0;
			degen_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						degen_q <= 1'b0;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						dcnt_q  <= '0;
						state_q <= S_CROSS;
					end
				end
				S_CROSS, S_SQ, S_C0, S_MAT: begin
					// A drain on dcnt_q lets the last product pass prod_s1 and acc_q and reach its target.
					if (dcnt_q == 2'd0) begin
						if (last_k) begin
							k_q <= '0;
							if (j_q == jmax) begin
								j_q <= '0;
								i_q <= i_q + 2'd1;
							end else begin
								j_q <= j_q + 2'd1;
							end
						end else begin
							k_q <= k_q + 2'd1;
						end
						if (last_all)
							dcnt_q <= 2'd1;
					end else if (dcnt_q == 2'd1) begin
						dcnt_q <= 2'd2;
					end else begin
						dcnt_q  <= '0;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= mac_next;
						if (state_q == S_CROSS)
							vsel_q <= 1'b0;
					end
				end
				S_LOAD: state_q <= S_SHIFT;
				S_SHIFT: begin
					if (stat.vec_zero) begin
						degen_q <= 1'b1;
						state_q <= S_FIN;
					end else if (stat.vec_norm) begin
						state_q <= S_SQ;
					end
				end
				S_SQRT: begin
					if (!go_q) begin
						go_q <= 1'b1;
					end else if (stat.sqrt_done) begin
						go_q    <= 1'b0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (!go_q) begin
						go_q <= 1'b1;
					end else if (stat.div_done) begin
						go_q <= 1'b0;
						if (i_q == 2'd2) begin
							i_q <= '0;
							if (vsel_q) begin
								state_q <= S_C0;
							end else begin
								vsel_q  <= 1'b1;
								state_q <= S_LOAD;
							end
						end else begin
							i_q <= i_q + 2'd1;
						end
					end
				end
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if ((state_q == S_FIN) && out_free)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the TRIAD attitude block.
// ----------------------------------------------------------------------------
// Directed and random accelerometer and magnetometer pairs, plus store and compute
// requests, are sent through the input channel. A bit-exact frame
// predictor runs beside the block. Each result item is compared field by
// field with the oldest expected matrix. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
	import triad_pkg::*;

	localparam int  RUN_LIMIT = 5000000;
	localparam bit  REQ_STORE = 1'b0;
	localparam bit  REQ_COMPUTE = 1'b1;

	typedef struct {
		logic signed [15:0] m [9];
		logic               rdy;
		logic               dgn;
	} attitude_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic req_type = 1'b0;
	sample_t accel_x = '0, accel_y = '0, accel_z = '0;
	sample_t mag_x = '0, mag_y = '0, mag_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	coef_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic ref_ready, degenerate;

	attitude_t expected_q[$];
	longint    ref_frame [3][3];
	bit        ref_stored;
	int        errors = 0;
	longint    cycles = 0;

	triad_attitude u_dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(10, 300);
	endfunction

	// Rounds a Q-scaled product sum half away from zero and clamps to one.
	function automatic longint round_clamp(longint x);
		longint mg, r;
		mg = x < 0 ? -x : x;
		r = (mg + (1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (r > (1 << FRAC_BITS)) r = 1 << FRAC_BITS;
		return x < 0 ? -r : r;
	endfunction

	function automatic longint int_sqrt(longint unsigned x);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	// Normalizes a signed vector to Q1.14; returns 0 for a zero vector.
	function automatic bit normalize(longint v [3], output longint u [3]);
		longint unsigned mg [3], s [3], mx, sum, n, q;
		int len;
		mx = 0;
		sum = 0;
		len = 0;
		for (int i = 0; i < 3; i++) begin
			mg[i] = v[i] < 0 ? -v[i] : v[i];
			if (mg[i] > mx) mx = mg[i];
		end
		if (mx == 0) return 1'b0;
		while (len < 64 && (mx >> len) != 0) len++;
		for (int i = 0; i < 3; i++) begin
			s[i] = len > NORM_BITS ? mg[i] >> (len - NORM_BITS)
				: mg[i] << (NORM_BITS - len);
			sum += s[i] * s[i];
		end
		n = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((s[i] << FRAC_BITS) + (n >> 1)) / n;
			u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1'b1;
	endfunction

	function automatic attitude_t predict_attitude(bit rq, longint a [3], longint g [3]);
		attitude_t e;
		longint cr [3], c1 [3], c2 [3], f [3][3], acc;
		bit ok;
		cr[0] = a[1] * g[2] - a[2] * g[1];
		cr[1] = a[2] * g[0] - a[0] * g[2];
		cr[2] = a[0] * g[1] - a[1] * g[0];
		ok = normalize(a, c2);
		if (ok) ok = normalize(cr, c1);
		for (int i = 0; i < 9; i++) e.m[i] = '0;
		if (ok) begin
			for (int i = 0; i < 3; i++) begin
				f[i][2] = c2[i];
				f[i][1] = c1[i];
			end
			f[0][0] = round_clamp(c1[1] * c2[2] - c1[2] * c2[1]);
			f[1][0] = round_clamp(c1[2] * c2[0] - c1[0] * c2[2]);
			f[2][0] = round_clamp(c1[0] * c2[1] - c1[1] * c2[0]);
			if (rq == REQ_STORE) begin
				ref_frame = f;
				ref_stored = 1'b1;
				for (int i = 0; i < 9; i++) e.m[i] = 16'(f[i / 3][i % 3]);
			end else begin
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++) begin
						acc = 0;
						for (int k = 0; k < 3; k++) acc += f[i][k] * ref_frame[j][k];
						e.m[i * 3 + j] = 16'(round_clamp(acc));
					end
			end
		end
		e.rdy = ref_stored;
		e.dgn = !ok;
		return e;
	endfunction

	// Valid stays high into the next item when there is no gap.
	task automatic send_item(bit rq, sample_t ax, sample_t ay, sample_t az,
			sample_t gx, sample_t gy, sample_t gz);
		longint a [3], g [3];
		int gap;
		gap = gap_len();
		a = '{ax, ay, az};
		g = '{gx, gy, gz};
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		expected_q.push_back(predict_attitude(rq, a, g));
		in_valid <= 1'b1;
		req_type <= rq;
		accel_x <= ax; accel_y <= ay; accel_z <= az;
		mag_x <= gx; mag_y <= gy; mag_z <= gz;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic sample_t rnd_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return sample_t'(16'h8000);
		if (r == 1) return sample_t'(16'h7FFF);
		if (r == 2) return sample_t'($urandom_range(0, 7)) - 16'sd3;
		return sample_t'($urandom);
	endfunction

	task automatic test_directed();
		send_item(REQ_COMPUTE, 0, 0, 16384, 1000, 0, 0);
		send_item(REQ_COMPUTE, 0, 0, 0, 100, 200, 300);
		send_item(REQ_STORE, 0, 0, 0, 1, 2, 3);
		send_item(REQ_STORE, 5, 5, 5, 10, 10, 10);
		send_item(REQ_STORE, 0, 0, 16384, 1000, 0, 0);
		send_item(REQ_COMPUTE, 0, 0, 16384, 1000, 0, 0);
		send_item(REQ_COMPUTE, 0, 0, 16384, 0, 1000, 0);
		send_item(REQ_COMPUTE, -32768, -32768, -32768, 32767, 32767, -32768);
		send_item(REQ_COMPUTE, 32767, 32767, 32767, -32768, 32767, 0);
		send_item(REQ_STORE, -32768, 32767, 1, 32767, -32768, -1);
		send_item(REQ_COMPUTE, -32768, 32767, 1, 32767, -32768, -1);
		send_item(REQ_COMPUTE, 1, 0, 0, 0, 1, 0);
		send_item(REQ_COMPUTE, 1, 0, 0, 0, 0, 0);
		send_item(REQ_COMPUTE, -1, -1, 0, 0, 0, -1);
		send_item(REQ_COMPUTE, 16'sh5555, -16'sh5556, 16'sh2AAA, -16'sh2AAB, 16'sh1234, -16'sh1);
	endtask

	task automatic test_random(int n);
		sample_t ax, ay, az, gx, gy, gz;
		int k;
		for (int i = 0; i < n; i++) begin
			ax = rnd_sample(); ay = rnd_sample(); az = rnd_sample();
			gx = rnd_sample(); gy = rnd_sample(); gz = rnd_sample();
			// Occasionally make the field parallel to the acceleration.
			if ($urandom_range(0, 19) == 0) begin
				k = $urandom_range(1, 2);
				ax = ax / 4; ay = ay / 4; az = az / 4;
				gx = sample_t'(ax * k); gy = sample_t'(ay * k); gz = sample_t'(az * k);
			end
			send_item($urandom_range(0, 3) == 0 ? REQ_STORE : REQ_COMPUTE,
				ax, ay, az, gx, gy, gz);
		end
	endtask

	initial begin
		ref_stored = 1'b0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) ref_frame[i][j] = (i == j) ? 1 << FRAC_BITS : 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(900);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Receiver stall pattern.
	initial begin
		int gap;
		forever begin
			gap = gap_len();
			out_ready <= 1'b0;
			repeat (gap) @(posedge clk);
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		attitude_t e;
		coef_t got [9];
		if (arst_n && out_valid && out_ready) begin
			got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result item", $time);
				errors++;
			end else begin
				e = expected_q.pop_front();
				for (int i = 0; i < 9; i++)
					if (got[i] !== e.m[i]) begin
						$display("%0t: m%0d%0d expected %0d actual %0d", $time,
							i / 3, i % 3, e.m[i], got[i]);
						errors++;
					end
				if (ref_ready !== e.rdy) begin
					$display("%0t: ref_ready expected %0b actual %0b", $time,
						e.rdy, ref_ready);
					errors++;
				end
				if (degenerate !== e.dgn) begin
					$display("%0t: degenerate expected %0b actual %0b", $time,
						e.dgn, degenerate);
					errors++;
				end
			end
		end
	end

endmodule
